>>> rtl/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types, widths and helpers of the edge crossing counter.
// ----------------------------------------------------------------------------
package ecc_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int ROW_W        = MAX_VERTICES;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int END_W        = 6;
	localparam int NV_W         = 7;
	localparam int CNT_W        = 22;
	localparam int POP_W        = $clog2(ROW_W + 1);
	localparam int MIN_VERTICES = 4;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CROSSING_LIMIT = 2'd1;

	localparam logic [NV_W-1:0]  VERTEX_COUNT_RST   = NV_W'(64);
	localparam logic [CNT_W-1:0] CROSSING_LIMIT_RST = {CNT_W{1'b1}};

	typedef struct packed {
		logic [END_W-1:0] end_a;
		logic [END_W-1:0] end_b;
		logic             last_edge;
	} edge_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] crossing_count;
		logic             limit_exceeded;
	} result_item_t;

	// one control word of the microprogram, as seen by the datapath
	typedef struct packed {
		logic accept;
		logic store_wr;
		logic cnt_init;
		logic rd_i;
		logic row_ld;
		logic k_init;
		logic rd_k;
		logic pop_ld;
		logic cnt_add;
		logic k_inc;
		logic j_inc;
		logic i_inc;
		logic set_over;
		logic emit;
	} ecc_ctl_t;

	// datapath conditions the sequencer can branch on
	typedef struct packed {
		logic no_in;
		logic not_last;
		logic n_small;
		logic i_end;
		logic j_end;
		logic bit_clr;
		logic over;
		logic k_more;
		logic out_busy;
	} ecc_flags_t;

	// bits counted per byte, then the byte counts summed
	function automatic logic [POP_W-1:0] popcount_row(input logic [ROW_W-1:0] v);
		localparam int NGRP = (ROW_W + 7) / 8;
		logic [NGRP*8-1:0] p;
		logic [3:0]        grp [NGRP];
		logic [POP_W-1:0]  sum;
		p = '0;
		p[ROW_W-1:0] = v;
		sum = '0;
		for (int g = 0; g < NGRP; g++) begin
			grp[g] = '0;
			for (int b = 0; b < 8; b++) begin
				grp[g] = grp[g] + 4'(p[g*8+b]);
			end
		end
		for (int g = 0; g < NGRP; g++) begin
			sum = sum + POP_W'(grp[g]);
		end
		return sum;
	endfunction

endpackage

>>> rtl/ecc_ram.sv
// ----------------------------------------------------------------------------
// ecc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ecc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/ecc_useq.sv
// ----------------------------------------------------------------------------
// ecc_useq
// Microcode sequencer: step counter, control store and branch logic.
// ----------------------------------------------------------------------------
module ecc_useq (
	input  logic              clk,
	input  logic              arst_n,
	input  ecc_pkg::ecc_flags_t flags,
	output ecc_pkg::ecc_ctl_t   ctl
);
	import ecc_pkg::*;

	localparam int STEP_W = 4;
	localparam int COND_W = 4;

	localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
	localparam logic [STEP_W-1:0] ST_STORE  = 4'd1;
	localparam logic [STEP_W-1:0] ST_INIT   = 4'd2;
	localparam logic [STEP_W-1:0] ST_I_TOP  = 4'd3;
	localparam logic [STEP_W-1:0] ST_I_LOAD = 4'd4;
	localparam logic [STEP_W-1:0] ST_J_TOP  = 4'd5;
	localparam logic [STEP_W-1:0] ST_J_TEST = 4'd6;
	localparam logic [STEP_W-1:0] ST_K_RD   = 4'd7;
	localparam logic [STEP_W-1:0] ST_K_POP  = 4'd8;
	localparam logic [STEP_W-1:0] ST_K_ADD  = 4'd9;
	localparam logic [STEP_W-1:0] ST_K_INC  = 4'd10;
	localparam logic [STEP_W-1:0] ST_J_INC  = 4'd11;
	localparam logic [STEP_W-1:0] ST_I_NEXT = 4'd12;
	localparam logic [STEP_W-1:0] ST_OVER   = 4'd14;
	localparam logic [STEP_W-1:0] ST_EMIT   = 4'd15;

	localparam logic [COND_W-1:0] C_NEVER    = 4'd0;
	localparam logic [COND_W-1:0] C_ALWAYS   = 4'd1;
	localparam logic [COND_W-1:0] C_NO_IN    = 4'd2;
	localparam logic [COND_W-1:0] C_NOT_LAST = 4'd3;
	localparam logic [COND_W-1:0] C_N_SMALL  = 4'd4;
	localparam logic [COND_W-1:0] C_I_END    = 4'd5;
	localparam logic [COND_W-1:0] C_J_END    = 4'd6;
	localparam logic [COND_W-1:0] C_BIT_CLR  = 4'd7;
	localparam logic [COND_W-1:0] C_OVER     = 4'd8;
	localparam logic [COND_W-1:0] C_K_MORE   = 4'd9;
	localparam logic [COND_W-1:0] C_OUT_BUSY = 4'd10;

	typedef struct packed {
		ecc_ctl_t            ctl;
		logic [COND_W-1:0]   cond;
		logic [STEP_W-1:0]   target;
	} ucode_t;

	// control store: a taken branch goes to target, otherwise to the next step
	function automatic ucode_t rom(input logic [STEP_W-1:0] s);
		ucode_t u;
		u = '0;
		unique case (s)
			ST_IDLE: begin
				u.ctl.accept = 1'b1;
				u.cond       = C_NO_IN;
				u.target     = ST_IDLE;
			end
			ST_STORE: begin
				u.ctl.store_wr = 1'b1;
				u.cond         = C_NOT_LAST;
				u.target       = ST_IDLE;
			end
			ST_INIT: begin
				u.ctl.cnt_init = 1'b1;
				u.cond         = C_N_SMALL;
				u.target       = ST_EMIT;
			end
			ST_I_TOP: begin
				u.ctl.rd_i = 1'b1;
				u.cond     = C_I_END;
				u.target   = ST_EMIT;
			end
			ST_I_LOAD: begin
				u.ctl.row_ld = 1'b1;
			end
			ST_J_TOP: begin
				u.cond   = C_J_END;
				u.target = ST_I_NEXT;
			end
			ST_J_TEST: begin
				u.ctl.k_init = 1'b1;
				u.cond       = C_BIT_CLR;
				u.target     = ST_J_INC;
			end
			ST_K_RD: begin
				u.ctl.rd_k = 1'b1;
			end
			ST_K_POP: begin
				u.ctl.pop_ld = 1'b1;
			end
			ST_K_ADD: begin
				u.ctl.cnt_add = 1'b1;
				u.cond        = C_OVER;
				u.target      = ST_OVER;
			end
			ST_K_INC: begin
				u.ctl.k_inc = 1'b1;
				u.cond      = C_K_MORE;
				u.target    = ST_K_RD;
			end
			ST_J_INC: begin
				u.ctl.j_inc = 1'b1;
				u.cond      = C_ALWAYS;
				u.target    = ST_J_TOP;
			end
			ST_I_NEXT: begin
				u.ctl.i_inc = 1'b1;
				u.cond      = C_ALWAYS;
				u.target    = ST_I_TOP;
			end
			ST_OVER: begin
				// falls through into the emit step
				u.ctl.set_over = 1'b1;
			end
			ST_EMIT: begin
				// waits while the result register is full and stalled, then wraps to idle
				u.ctl.emit = 1'b1;
				u.cond     = C_OUT_BUSY;
				u.target   = ST_EMIT;
			end
			default: begin
				u.cond   = C_ALWAYS;
				u.target = ST_IDLE;
			end
		endcase
		return u;
	endfunction

	logic [STEP_W-1:0] step_q;
	ucode_t            uc;
	logic              take;

	assign uc  = rom(step_q);
	assign ctl = uc.ctl;

	always_comb begin
		unique case (uc.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_IN:    take = flags.no_in;
			C_NOT_LAST: take = flags.not_last;
			C_N_SMALL:  take = flags.n_small;
			C_I_END:    take = flags.i_end;
			C_J_END:    take = flags.j_end;
			C_BIT_CLR:  take = flags.bit_clr;
			C_OVER:     take = flags.over;
			C_K_MORE:   take = flags.k_more;
			C_OUT_BUSY: take = flags.out_busy;
			default:    take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= take ? uc.target : step_q + STEP_W'(1);
		end
	end

endmodule

>>> rtl/ecc_datapath.sv
// ----------------------------------------------------------------------------
// ecc_datapath
// Adjacency row store, loop counters, popcount accumulator and result register.
// ----------------------------------------------------------------------------
module ecc_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         edge_valid,
	output logic                         edge_stall,
	input  ecc_pkg::edge_item_t          edge_item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output ecc_pkg::result_item_t        result,
	input  logic [ecc_pkg::NV_W-1:0]     vertex_count,
	input  logic [ecc_pkg::CNT_W-1:0]    crossing_limit,
	input  ecc_pkg::ecc_ctl_t            ctl,
	output ecc_pkg::ecc_flags_t          flags
);
	import ecc_pkg::*;

	// store holds only the upper triangle: row of the lower endpoint
	logic [ADDR_W-1:0] lo_q;
	logic [ADDR_W-1:0] hi_q;
	logic              last_q;
	logic [NV_W-1:0]   i_q;
	logic [NV_W-1:0]   j_q;
	logic [ADDR_W-1:0] k_q;
	logic [ROW_W-1:0]  row_i_q;
	logic [POP_W-1:0]  pop_q;
	logic [CNT_W-1:0]  count_q;
	logic              over_q;
	logic [ROW_W-1:0]  valid_q;
	logic              rd_ok_q;
	logic              result_valid_q;
	result_item_t      result_q;

	logic [ADDR_W-1:0] lo_in;
	logic [ADDR_W-1:0] hi_in;
	logic [ADDR_W-1:0] raddr;
	logic              re;
	logic [ROW_W-1:0]  rdata;
	logic [ROW_W-1:0]  rdata_m;
	logic [ROW_W-1:0]  wdata;
	logic [NV_W-1:0]   n_eff;
	logic [ROW_W-1:0]  nmask;
	logic [ROW_W-1:0]  above_j;
	logic [CNT_W:0]    sum;
	logic              accept;
	logic              out_busy;
	logic              emit_go;

	assign lo_in = (edge_item.end_a < edge_item.end_b) ? edge_item.end_a : edge_item.end_b;
	assign hi_in = (edge_item.end_a < edge_item.end_b) ? edge_item.end_b : edge_item.end_a;

	assign edge_stall = !ctl.accept;
	assign accept     = edge_valid && ctl.accept;

	assign n_eff = (vertex_count > NV_W'(MAX_VERTICES)) ? NV_W'(MAX_VERTICES) : vertex_count;

	always_comb begin
		for (int b = 0; b < ROW_W; b++) begin
			nmask[b] = (NV_W'(b) < n_eff);
		end
	end

	// neighbours strictly above j
	assign above_j = ({ROW_W{1'b1}} << j_q[ADDR_W-1:0]) << 1;

	assign raddr = ctl.accept ? lo_in : (ctl.rd_k ? k_q : i_q[ADDR_W-1:0]);
	assign re    = ctl.accept || ctl.rd_i || ctl.rd_k;

	// a row never written since the last result reads as zero
	assign rdata_m = rd_ok_q ? rdata : '0;
	assign wdata   = rdata_m | (ROW_W'(1) << hi_q);

	ecc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_VERTICES)
	) u_rows (
		.clk   (clk),
		.we    (ctl.store_wr),
		.waddr (lo_q),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign sum      = {1'b0, count_q} + (CNT_W+1)'(pop_q);
	assign out_busy = result_valid_q && result_stall;
	assign emit_go  = ctl.emit && !out_busy;

	assign flags.no_in    = !edge_valid;
	assign flags.not_last = !last_q;
	assign flags.n_small  = n_eff < NV_W'(MIN_VERTICES);
	assign flags.i_end    = i_q >= n_eff;
	assign flags.j_end    = j_q >= n_eff;
	assign flags.bit_clr  = !row_i_q[j_q[ADDR_W-1:0]];
	assign flags.over     = sum > {1'b0, crossing_limit};
	assign flags.k_more   = (NV_W'(k_q) + NV_W'(1)) < j_q;
	assign flags.out_busy = out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				valid_q <= '0;
			end else if (ctl.store_wr) begin
				valid_q[lo_q] <= 1'b1;
			end
			if (emit_go) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q   <= lo_in;
			hi_q   <= hi_in;
			last_q <= edge_item.last_edge;
		end
		if (re) begin
			rd_ok_q <= valid_q[raddr];
		end
		if (ctl.cnt_init) begin
			count_q <= '0;
			over_q  <= 1'b0;
			i_q     <= '0;
		end
		if (ctl.row_ld) begin
			row_i_q <= rdata_m & nmask;
			j_q     <= i_q + NV_W'(2);
		end
		if (ctl.k_init) begin
			k_q <= i_q[ADDR_W-1:0] + ADDR_W'(1);
		end
		if (ctl.pop_ld) begin
			pop_q <= popcount_row(rdata_m & nmask & above_j);
		end
		if (ctl.cnt_add) begin
			count_q <= sum[CNT_W-1:0];
		end
		if (ctl.k_inc) begin
			k_q <= k_q + ADDR_W'(1);
		end
		if (ctl.j_inc) begin
			j_q <= j_q + NV_W'(1);
		end
		if (ctl.i_inc) begin
			i_q <= i_q + NV_W'(1);
		end
		if (ctl.set_over) begin
			count_q <= crossing_limit + CNT_W'(1);
			over_q  <= 1'b1;
		end
		if (emit_go) begin
			result_q.crossing_count <= count_q;
			result_q.limit_exceeded <= over_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> rtl/edge_crossing_counter_unit.sv
// ----------------------------------------------------------------------------
// edge_crossing_counter_unit
// Counts crossing edge pairs of a graph laid out on a line.
//
// Edges come in on the edge channel (valid/stall), one per item, and each
// is a read and a write of one adjacency row. The item with last_edge set
// also starts the count; one result then leaves on the result channel. The
// count walks rows i, partners j > i+1 and, for every stored edge i-j, the
// rows k between them, each with one read of the row store, popcount and add.
// Fewer than 4 vertices give 0. Counting ends early past the limit. The
// result sits in an output register, so the next graph's edges are taken
// while it waits; a stalled result holds the block only if the next count
// finishes first. Configuration goes in over cfg_valid/cfg_ready; the user
// must write it only while idle, which the block does not enforce. Reset
// empties the store (per-row valid bits, no clearing pass) and loads 64
// vertices and the largest limit.
// ----------------------------------------------------------------------------
module edge_crossing_counter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          edge_valid,
	output logic                          edge_stall,
	input  ecc_pkg::edge_item_t           edge_item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output ecc_pkg::result_item_t         result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ecc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ecc_pkg::CNT_W-1:0]     cfg_data
);
	import ecc_pkg::*;

	logic [NV_W-1:0]  vertex_count_q;
	logic [CNT_W-1:0] crossing_limit_q;
	ecc_ctl_t         ctl;
	ecc_flags_t       flags;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q   <= VERTEX_COUNT_RST;
			crossing_limit_q <= CROSSING_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_VERTEX_COUNT:   vertex_count_q   <= cfg_data[NV_W-1:0];
				CFG_CROSSING_LIMIT: crossing_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ecc_useq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	ecc_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.edge_valid     (edge_valid),
		.edge_stall     (edge_stall),
		.edge_item      (edge_item),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result),
		.vertex_count   (vertex_count_q),
		.crossing_limit (crossing_limit_q),
		.ctl            (ctl),
		.flags          (flags)
	);

`ifndef SYNTHESIS
	// after an edge that is not last, the input stalls while its row is written, then is taken again
	a_edge_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		(edge_valid && !edge_stall && !edge_item.last_edge) |=> edge_stall ##1 !edge_stall)
		else $error("edge item not stored in two cycles");

	// a new result only appears after a count, never while edges are taken
	a_result_after_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(edge_stall))
		else $error("result raised while idle");

	a_exceeded_value: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.limit_exceeded) |->
		result.crossing_count == CNT_W'(crossing_limit_q + CNT_W'(1)))
		else $error("exceeded result is not limit plus one");

	a_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.limit_exceeded) |->
		result.crossing_count <= crossing_limit_q)
		else $error("count above limit without flag");
`endif

endmodule

>>> dv/crossing_count_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crossing_count_checker
// Watches the edge, result and configuration channels of the crossing
// counter, keeps its own adjacency store and register copies, works out the
// crossing count of every finished graph and compares it with what leaves.
// ----------------------------------------------------------------------------
module crossing_count_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          edge_valid,
	input  logic                          edge_stall,
	input  ecc_pkg::edge_item_t           edge_data,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  ecc_pkg::result_item_t         result_data,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [ecc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ecc_pkg::CNT_W-1:0]     cfg_data,
	output int                            mismatch_count,
	output int                            pending_results
);
	import ecc_pkg::*;

	logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES] = '{default: '0};
	logic [NV_W-1:0]         vertices = VERTEX_COUNT_RST;
	logic [CNT_W-1:0]        limit    = CROSSING_LIMIT_RST;
	result_item_t            expected_tallies [$];
	int                      mismatches = 0;
	int                      pending    = 0;

	assign mismatch_count  = mismatches;
	assign pending_results = pending;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic add_expected(input result_item_t item);
		expected_tallies.insert(expected_tallies.size(), item);
	endtask

	// pairs i<j, k between them, neighbours of k beyond j; stops past the limit
	function automatic result_item_t tally_crossings();
		result_item_t            r;
		int unsigned             nv;
		int unsigned             tally;
		int unsigned             add;
		logic [MAX_VERTICES-1:0] nmask;
		logic [MAX_VERTICES-1:0] row_i;
		logic [MAX_VERTICES-1:0] above_j;
		r = '0;
		tally = 0;
		nv = (vertices > MAX_VERTICES) ? MAX_VERTICES : vertices;
		if (nv < MIN_VERTICES)
			return r;
		nmask = (nv == MAX_VERTICES) ? '1 : ((64'd1 << nv) - 64'd1);
		for (int i = 0; i < nv; i++) begin
			row_i = adj_rows[i] & nmask;
			for (int j = i + 2; j < nv; j++) begin
				if (row_i[j]) begin
					above_j = ~((64'd2 << j) - 64'd1);
					for (int k = i + 1; k < j; k++) begin
						add = $countones(adj_rows[k] & nmask & above_j);
						if (tally + add > limit) begin
							r.crossing_count = CNT_W'(limit + 1);
							r.limit_exceeded = 1'b1;
							return r;
						end
						tally += add;
					end
				end
			end
		end
		r.crossing_count = CNT_W'(tally);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_item_t exp_item;
		if (!arst_n) begin
			foreach (adj_rows[r]) adj_rows[r] = '0;
			vertices = VERTEX_COUNT_RST;
			limit    = CROSSING_LIMIT_RST;
			expected_tallies.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_VERTEX_COUNT:   vertices = cfg_data[NV_W-1:0];
					CFG_CROSSING_LIMIT: limit    = cfg_data;
					default: ;
				endcase
			end
			if (edge_valid && !edge_stall) begin
				adj_rows[edge_data.end_a][edge_data.end_b] = 1'b1;
				adj_rows[edge_data.end_b][edge_data.end_a] = 1'b1;
				if (edge_data.last_edge) begin
					add_expected(tally_crossings());
					foreach (adj_rows[r]) adj_rows[r] = '0;
				end
			end
			if (result_valid && !result_stall) begin
				if (expected_tallies.size() == 0) begin
					report_mismatch($sformatf("unexpected result, count %0d flag %0b",
						result_data.crossing_count, result_data.limit_exceeded));
				end else begin
					exp_item = expected_tallies.pop_front();
					if (result_data.crossing_count !== exp_item.crossing_count)
						report_mismatch($sformatf("crossing_count %0d, expected %0d",
							result_data.crossing_count, exp_item.crossing_count));
					if (result_data.limit_exceeded !== exp_item.limit_exceeded)
						report_mismatch($sformatf("limit_exceeded %0b, expected %0b",
							result_data.limit_exceeded, exp_item.limit_exceeded));
				end
			end
		end
		pending = expected_tallies.size();
	end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives graphs into the edge crossing counter under several vertex counts
// and limits, with random gaps and stalls, and gives the verdict from the
// checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
	import ecc_pkg::*;

	localparam int ITEM_TARGET   = 1350;
	localparam int CYCLE_LIMIT   = 40000000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 16;
	localparam int IDLE_PCT      = 26;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 edge_valid   = 1'b0;
	logic                 edge_stall;
	edge_item_t           edge_data    = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_item_t         result_data;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = CFG_VERTEX_COUNT;
	logic [CNT_W-1:0]     cfg_data     = '0;

	int mismatch_count;
	int pending_results;
	int items_sent  = 0;
	int cycle_count = 0;
	int hold_req    = 0;
	int hold_done   = 0;
	bit quiet       = 1'b0;

	edge_crossing_counter_unit dut (
		clk, arst_n,
		edge_valid, edge_stall, edge_data,
		result_valid, result_stall, result_data,
		cfg_valid, cfg_ready, cfg_index, cfg_data
	);

	crossing_count_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.edge_valid      (edge_valid),
		.edge_stall      (edge_stall),
		.edge_data       (edge_data),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result_data     (result_data),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_done != hold_req) begin
				result_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done++;
			end
			result_stall = !quiet && ($urandom_range(99) < IDLE_PCT);
		end
	end

	task automatic send_edge(input logic [END_W-1:0] a, input logic [END_W-1:0] b,
			input logic last);
		if (!quiet && $urandom_range(99) < IDLE_PCT) begin
			edge_valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		edge_data  = '{end_a: a, end_b: b, last_edge: last};
		edge_valid = 1'b1;
		@(posedge clk);
		while (edge_stall) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// wait until every graph sent so far has produced its result
	task automatic settle();
		edge_valid = 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
		settle();
		cfg_index = idx;
		cfg_data  = val;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// mostly endpoints inside the arrangement, some anywhere in the store
	task automatic send_graph(input int nv, input int edge_total);
		int             span;
		logic [END_W-1:0] a;
		logic [END_W-1:0] b;
		span = (nv > MAX_VERTICES) ? MAX_VERTICES : nv;
		for (int e = 0; e < edge_total; e++) begin
			if (span >= 2 && $urandom_range(99) < 85) begin
				a = END_W'($urandom_range(0, span - 1));
				b = END_W'($urandom_range(0, span - 1));
			end else begin
				a = END_W'($urandom_range(0, 63));
				b = END_W'($urandom_range(0, 63));
			end
			send_edge(a, b, e == edge_total - 1);
		end
	endtask

	initial begin
		int               nv;
		int               r;
		int               graphs;
		int               phase;
		logic [CNT_W-1:0] lim;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// one crossing pair
		send_edge(0, 2, 1'b0);
		send_edge(1, 3, 1'b1);
		// self loop and repeated edges
		send_edge(5, 5, 1'b0);
		send_edge(0, 2, 1'b0);
		send_edge(2, 0, 1'b0);
		send_edge(1, 3, 1'b0);
		send_edge(1, 3, 1'b1);
		// extreme positions, nested edges only
		send_edge(63, 0, 1'b0);
		send_edge(0, 63, 1'b0);
		send_edge(63, 63, 1'b0);
		send_edge(62, 1, 1'b0);
		send_edge(21, 42, 1'b1);

		// too few vertices
		write_reg(CFG_VERTEX_COUNT, CNT_W'(3));
		send_edge(0, 2, 1'b0);
		send_edge(1, 3, 1'b1);

		// zero limit: exceeded on the first crossing, clean without one
		write_reg(CFG_VERTEX_COUNT, CNT_W'(5));
		write_reg(CFG_CROSSING_LIMIT, '0);
		send_edge(0, 2, 1'b0);
		send_edge(1, 3, 1'b1);
		send_edge(0, 2, 1'b0);
		send_edge(1, 9, 1'b1);

		// vertex count above the store size
		write_reg(CFG_VERTEX_COUNT, CNT_W'(127));
		write_reg(CFG_CROSSING_LIMIT, CROSSING_LIMIT_RST);
		send_edge(0, 40, 1'b0);
		send_edge(20, 63, 1'b1);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			r = $urandom_range(99);
			if (r < 5)
				nv = $urandom_range(0, 3);
			else if (r < 80)
				nv = $urandom_range(4, 12);
			else if (r < 93)
				nv = $urandom_range(13, 32);
			else if (r < 97)
				nv = MAX_VERTICES;
			else
				nv = $urandom_range(65, 127);
			r = $urandom_range(99);
			if (r < 55)
				lim = CROSSING_LIMIT_RST;
			else if (r < 75)
				lim = CNT_W'($urandom_range(0, 8));
			else if (r < 90)
				lim = CNT_W'($urandom_range(9, 200));
			else
				lim = CNT_W'($urandom());
			graphs = $urandom_range(3, 8);
			// first phase: results held back so the block backs up its input
			if (phase == 0) begin
				nv     = 6;
				lim    = CROSSING_LIMIT_RST;
				graphs = 8;
			end
			write_reg(CFG_VERTEX_COUNT, CNT_W'(nv));
			write_reg(CFG_CROSSING_LIMIT, lim);
			quiet = (phase >= 3 && phase < 6);
			if (phase == 0)
				hold_req++;
			repeat (graphs)
				send_graph(nv, (nv > 32) ? $urandom_range(1, 20) : $urandom_range(1, 12));
			phase++;
		end

		settle();
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
